// ===== hw/rtl/sfr_pkg.sv =====
// shared types, codes and constants of the sliding-window frame receiver
package sfr_pkg;

  // input opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_ADDR = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  // configuration reset values
  localparam logic [7:0]  NODE_ADDR_RST = 8'h02;
  localparam logic [7:0]  WINDOW_RST    = 8'd4;
  localparam logic [15:0] TIMEOUT_RST   = 16'd2000;

  // frame format
  localparam logic [7:0] FLAG_BYTE      = 8'h7E;
  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
  localparam int         FRAME_OVERHEAD = 10;
  localparam int         MAX_PAYLOAD_DEF = 64;

  // control bytes
  localparam logic [7:0] CTL_DATA      = 8'h01;
  localparam logic [7:0] CTL_HANDSHAKE = 8'h04;
  localparam logic [7:0] CTL_FINISH    = 8'h05;
  localparam logic [7:0] CTL_REM_ERROR = 8'h06;

  // event codes
  localparam logic [3:0] EV_BAD_FRAME = 4'd0;
  localparam logic [3:0] EV_NOT_ADDR  = 4'd1;
  localparam logic [3:0] EV_HANDSHAKE = 4'd2;
  localparam logic [3:0] EV_DATA      = 4'd3;
  localparam logic [3:0] EV_DUPLICATE = 4'd4;
  localparam logic [3:0] EV_FINISH    = 4'd5;
  localparam logic [3:0] EV_REM_ERROR = 4'd6;
  localparam logic [3:0] EV_UNKNOWN   = 4'd7;
  localparam logic [3:0] EV_IGNORED   = 4'd8;
  localparam logic [3:0] EV_TIMEOUT   = 4'd9;

  // receiver states
  localparam logic [1:0] RX_WAITING   = 2'd0;
  localparam logic [1:0] RX_RECEIVING = 2'd1;
  localparam logic [1:0] RX_COMPLETE  = 2'd2;
  localparam logic [1:0] RX_ERROR     = 2'd3;

  // kinds of word passed from front to back
  localparam logic [1:0] K_FRAME_OK  = 2'd0;
  localparam logic [1:0] K_FRAME_BAD = 2'd1;
  localparam logic [1:0] K_TICK      = 2'd2;
  localparam logic [1:0] K_RESET     = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  address;
    logic [7:0]  control;
    logic [7:0]  sequence_no;
    logic [15:0] length;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  node_address;
    logic [7:0]  window_size;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== hw/rtl/sfr_if.sv =====
// valid/ready channel interfaces for input words and result words
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, opcode, data_byte, last_byte, input ready);
  modport sink (input valid, opcode, data_byte, last_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic        ack_sent;
  logic [7:0]  ack_number;
  logic [1:0]  receiver_state;
  logic [15:0] frames_received;
  logic [31:0] bytes_received;
  logic [7:0]  error_count;
  modport source (output valid, event_res, ack_sent, ack_number, receiver_state,
                  frames_received, bytes_received, error_count, input ready);
  modport sink (input valid, event_res, ack_sent, ack_number, receiver_state,
                frames_received, bytes_received, error_count, output ready);
endinterface

// ===== hw/rtl/sfr_front.sv =====
// front end: assembles frame bytes, checks framing and classifies words
module sfr_front
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  sfr_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_cmd
);

  localparam int FRAME_MAX = MAX_PAYLOAD + FRAME_OVERHEAD;
  localparam int POS_W     = $clog2(FRAME_MAX + 1);
  localparam int TOT_W     = 17;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             bad_r, bad_nxt;
  logic [7:0]       addr_r, addr_nxt, ctl_r, ctl_nxt, seq_r, seq_nxt;
  logic [15:0]      len_r, len_nxt;
  logic             acc, at_end, ok;
  logic [TOT_W-1:0] total, expect_total;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;
  assign at_end = (pos_r >= POS_W'(FRAME_MAX));

  // byte assembly
  always_comb begin
    pos_nxt  = pos_r;
    bad_nxt  = bad_r;
    addr_nxt = addr_r;
    ctl_nxt  = ctl_r;
    seq_nxt  = seq_r;
    len_nxt  = len_r;
    push     = 1'b0;
    ok       = 1'b0;
    total        = TOT_W'(pos_r) + TOT_W'(1);
    expect_total = TOT_W'(FRAME_OVERHEAD) + TOT_W'(len_r);
    push_cmd = '{kind: K_TICK, address: addr_r, control: ctl_r,
                 sequence_no: seq_r, length: len_r};
    if (acc) begin
      unique case (in_ch.opcode)
        OP_BYTE: begin
          if (at_end) begin
            bad_nxt = 1'b1;
          end else if (pos_r == '0) begin
            if (in_ch.data_byte != FLAG_BYTE) bad_nxt = 1'b1;
          end else if (pos_r == POS_W'(1)) begin
            addr_nxt = in_ch.data_byte;
          end else if (pos_r == POS_W'(2)) begin
            ctl_nxt = in_ch.data_byte;
          end else if (pos_r == POS_W'(3)) begin
            seq_nxt = in_ch.data_byte;
          end else if (pos_r == POS_W'(5)) begin
            len_nxt = {in_ch.data_byte, len_r[7:0]};
          end else if (pos_r == POS_W'(6)) begin
            len_nxt = {len_r[15:8], in_ch.data_byte};
          end
          if (!in_ch.last_byte) begin
            if (!at_end) pos_nxt = pos_r + POS_W'(1);
          end else begin
            expect_total = TOT_W'(FRAME_OVERHEAD) + TOT_W'(len_nxt);
            ok = !bad_nxt && (total >= TOT_W'(FRAME_OVERHEAD)) &&
                 (in_ch.data_byte == FLAG_BYTE) && (total == expect_total) &&
                 (len_nxt <= 16'(MAX_PAYLOAD));
            push = 1'b1;
            push_cmd = '{kind: ok ? K_FRAME_OK : K_FRAME_BAD, address: addr_nxt,
                         control: ctl_nxt, sequence_no: seq_nxt, length: len_nxt};
            pos_nxt = '0;
            bad_nxt = 1'b0;
          end
        end
        OP_TICK: begin
          push = 1'b1;
        end
        OP_RESET: begin
          push = 1'b1;
          push_cmd.kind = K_RESET;
          pos_nxt = '0;
          bad_nxt = 1'b0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bad_r  <= 1'b0;
      addr_r <= '0;
      ctl_r  <= '0;
      seq_r  <= '0;
      len_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      addr_r <= addr_nxt;
      ctl_r  <= ctl_nxt;
      seq_r  <= seq_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

// ===== hw/rtl/sfr_queue.sv =====
// short fifo of classified words between front and back
module sfr_queue
  import sfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + AW'(1);
      if (pop) rd_r <= rd_r + AW'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ===== hw/rtl/sfr_back.sv =====
// back end: protocol state, window check, counters, idle timer and result register
module sfr_back
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  cmd_t     q_cmd,
  output logic     pop,
  sfr_out_if.source out_ch
);

  logic [1:0]  rx_r, rx_nxt;
  logic [7:0]  exp_r, exp_nxt, rerr_r, rerr_nxt;
  logic [15:0] fc_r, fc_nxt, idle_r, idle_nxt, tick_inc;
  logic [31:0] bc_r, bc_nxt;
  logic        emit, ack;
  logic [3:0]  ev;
  logic [7:0]  ack_num, seq_off;
  logic        addressed;

  logic        ov_r;
  logic [3:0]  ev_r;
  logic        ack_r;
  logic [7:0]  ackn_r, rerr_o_r;
  logic [1:0]  st_o_r;
  logic [15:0] fc_o_r;
  logic [31:0] bc_o_r;

  assign pop = q_valid && (!ov_r || out_ch.ready);
  assign tick_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign seq_off = q_cmd.sequence_no - exp_r;
  assign addressed = (q_cmd.address == cfg.node_address) ||
                     (q_cmd.address == BROADCAST_ADDR);

  // word execution
  always_comb begin
    rx_nxt   = rx_r;
    exp_nxt  = exp_r;
    rerr_nxt = rerr_r;
    fc_nxt   = fc_r;
    bc_nxt   = bc_r;
    idle_nxt = idle_r;
    emit     = 1'b0;
    ack      = 1'b0;
    ev       = EV_BAD_FRAME;
    ack_num  = 8'd0;
    if (pop) begin
      unique case (q_cmd.kind)
        K_TICK: begin
          if (rx_r == RX_RECEIVING && tick_inc > cfg.timeout_ticks) begin
            rx_nxt   = RX_ERROR;
            idle_nxt = 16'd0;
            emit     = 1'b1;
            ev       = EV_TIMEOUT;
          end else begin
            idle_nxt = tick_inc;
          end
        end
        K_RESET: begin
          rx_nxt   = RX_WAITING;
          fc_nxt   = 16'd0;
          bc_nxt   = 32'd0;
          rerr_nxt = 8'd0;
          exp_nxt  = 8'd0;
        end
        K_FRAME_BAD: begin
          emit = 1'b1;
          ev   = EV_BAD_FRAME;
        end
        default: begin
          emit     = 1'b1;
          idle_nxt = 16'd0;
          if (!addressed) begin
            ev = EV_NOT_ADDR;
          end else begin
            unique case (q_cmd.control)
              CTL_HANDSHAKE: begin
                if (rx_r == RX_WAITING) begin
                  rx_nxt = RX_RECEIVING;
                  fc_nxt = 16'd0;
                  bc_nxt = 32'd0;
                  ev     = EV_HANDSHAKE;
                  ack    = 1'b1;
                end else begin
                  ev = EV_IGNORED;
                end
              end
              CTL_DATA: begin
                if (rx_r == RX_RECEIVING) begin
                  ack = 1'b1;
                  if (seq_off < cfg.window_size) begin
                    fc_nxt = fc_r + 16'd1;
                    bc_nxt = bc_r + 32'(q_cmd.length);
                    if (q_cmd.sequence_no == exp_r) exp_nxt = exp_r + 8'd1;
                    ev = EV_DATA;
                  end else begin
                    ev = EV_DUPLICATE;
                  end
                  ack_num = exp_nxt;
                end else begin
                  ev = EV_IGNORED;
                end
              end
              CTL_FINISH: begin
                if (rx_r == RX_RECEIVING) begin
                  rx_nxt  = RX_COMPLETE;
                  ev      = EV_FINISH;
                  ack     = 1'b1;
                  ack_num = exp_r;
                end else begin
                  ev = EV_IGNORED;
                end
              end
              CTL_REM_ERROR: begin
                rx_nxt   = RX_ERROR;
                rerr_nxt = rerr_r + 8'd1;
                ev       = EV_REM_ERROR;
              end
              default: begin
                ev = EV_UNKNOWN;
              end
            endcase
          end
        end
      endcase
    end
  end

  // protocol state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r   <= RX_WAITING;
      exp_r  <= '0;
      rerr_r <= '0;
      fc_r   <= '0;
      bc_r   <= '0;
      idle_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      rx_r   <= rx_nxt;
      exp_r  <= exp_nxt;
      rerr_r <= rerr_nxt;
      fc_r   <= fc_nxt;
      bc_r   <= bc_nxt;
      idle_r <= idle_nxt;
      if (pop) ov_r <= emit;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      ev_r     <= ev;
      ack_r    <= ack;
      ackn_r   <= ack_num;
      st_o_r   <= rx_nxt;
      fc_o_r   <= fc_nxt;
      bc_o_r   <= bc_nxt;
      rerr_o_r <= rerr_nxt;
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.event_res       = ev_r;
  assign out_ch.ack_sent        = ack_r;
  assign out_ch.ack_number      = ackn_r;
  assign out_ch.receiver_state  = st_o_r;
  assign out_ch.frames_received = fc_o_r;
  assign out_ch.bytes_received  = bc_o_r;
  assign out_ch.error_count     = rerr_o_r;

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_cmd.kind == K_RESET |=> rx_r == RX_WAITING && fc_r == '0 &&
    bc_r == '0 && rerr_r == '0 && exp_r == '0) else $error("reset word left state");
  a_timeout_err: assert property (@(posedge clk) disable iff (!rst_n)
    pop && emit && ev == EV_TIMEOUT |=> rx_r == RX_ERROR && idle_r == '0)
    else $error("timeout did not enter error");
  a_no_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |-> !pop) else $error("word taken over pending result");

endmodule

// ===== hw/rtl/sliding_window_frame_receiver.sv =====
// Sliding-window frame receiver: takes one word per cycle while the queue has
// room (frame byte, tick or receiver reset) and gives at most one event per
// word. A front stage builds frames and checks flags and length, a four-word
// queue decouples it from the back stage, which runs the handshake/data/finish
// protocol, the window check and the idle timer, and holds each event in an
// output register. Sustained rate is one word per cycle while results are
// taken; an event passes the queue and then the output register, later only
// while an earlier event waits there. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does not check.
module sliding_window_frame_receiver
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sfr_in_if.sink      in_ch,
  sfr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  logic push, full, q_valid, pop;
  cmd_t push_cmd, q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{node_address: NODE_ADDR_RST, window_size: WINDOW_RST,
                 timeout_ticks: TIMEOUT_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ADDR: cfg_r.node_address  <= cfg_wdata[7:0];
        REG_WINDOW:    cfg_r.window_size   <= cfg_wdata[7:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks <= cfg_wdata;
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  sfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk, .rst_n, .in_ch, .q_full(full), .push, .push_cmd
  );

  sfr_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .full, .q_valid, .q_cmd, .pop
  );

  sfr_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_cmd, .pop, .out_ch
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the sliding-window frame receiver
module testbench;
  import sfr_pkg::*;

  localparam int FRAME_LIMIT = MAX_PAYLOAD_DEF + FRAME_OVERHEAD;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 450;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } rx_word_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic        ack_sent;
    logic [7:0]  ack_number;
    logic [1:0]  receiver_state;
    logic [15:0] frames_received;
    logic [31:0] bytes_received;
    logic [7:0]  error_count;
  } rx_event_t;

  typedef enum int {FLAW_NONE, FLAW_START, FLAW_END, FLAW_TRUNC} frame_flaw_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  sliding_window_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // words waiting to be sent and events still to arrive
  rx_word_t  pending_words[$];
  rx_event_t expected_events[$];

  // predictor copy of configuration and state
  logic [7:0]  own_addr;
  logic [7:0]  window;
  logic [15:0] idle_limit;
  logic [1:0]  rx_state;
  int          byte_pos;
  logic        frame_bad;
  logic [7:0]  hdr_addr, hdr_ctl, hdr_seq;
  logic [15:0] pay_len;
  logic [7:0]  next_seq;
  logic [15:0] frame_cnt;
  logic [31:0] byte_cnt;
  logic [7:0]  remote_errs;
  logic [15:0] idle_cnt;

  int  cycles;
  int  accepted_words;
  int  mismatches;
  bit  failed;
  bit  word_taken;
  int  hold_left;
  bit  hold_done;
  logic [7:0] gen_seq;

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // queue one expected event from the current predictor state
  function automatic void push_event(logic [3:0] ev, logic ack, logic [7:0] num);
    rx_event_t e;
    e.event_res       = ev;
    e.ack_sent        = ack;
    e.ack_number      = ack ? num : 8'd0;
    e.receiver_state  = rx_state;
    e.frames_received = frame_cnt;
    e.bytes_received  = byte_cnt;
    e.error_count     = remote_errs;
    expected_events.push_back(e);
  endfunction

  // protocol handling of a well-formed frame
  function automatic void handle_good_frame();
    idle_cnt = '0;
    if (hdr_addr != own_addr && hdr_addr != BROADCAST_ADDR) begin
      push_event(EV_NOT_ADDR, 1'b0, 8'd0);
      return;
    end
    case (hdr_ctl)
      CTL_HANDSHAKE: begin
        if (rx_state == RX_WAITING) begin
          rx_state  = RX_RECEIVING;
          frame_cnt = '0;
          byte_cnt  = '0;
          push_event(EV_HANDSHAKE, 1'b1, 8'd0);
        end else begin
          push_event(EV_IGNORED, 1'b0, 8'd0);
        end
      end
      CTL_DATA: begin
        if (rx_state == RX_RECEIVING) begin
          if (8'(hdr_seq - next_seq) < window) begin
            frame_cnt = frame_cnt + 16'd1;
            byte_cnt  = byte_cnt + 32'(pay_len);
            if (hdr_seq == next_seq) next_seq = next_seq + 8'd1;
            push_event(EV_DATA, 1'b1, next_seq);
          end else begin
            push_event(EV_DUPLICATE, 1'b1, next_seq);
          end
        end else begin
          push_event(EV_IGNORED, 1'b0, 8'd0);
        end
      end
      CTL_FINISH: begin
        if (rx_state == RX_RECEIVING) begin
          rx_state = RX_COMPLETE;
          push_event(EV_FINISH, 1'b1, next_seq);
        end else begin
          push_event(EV_IGNORED, 1'b0, 8'd0);
        end
      end
      CTL_REM_ERROR: begin
        rx_state    = RX_ERROR;
        remote_errs = remote_errs + 8'd1;
        push_event(EV_REM_ERROR, 1'b0, 8'd0);
      end
      default: push_event(EV_UNKNOWN, 1'b0, 8'd0);
    endcase
  endfunction

  // work out the event of one accepted word
  function automatic void frame_rx_predict(rx_word_t w);
    int total;
    bit ok;
    case (w.opcode)
      OP_TICK: begin
        if (idle_cnt != 16'hFFFF) idle_cnt = idle_cnt + 16'd1;
        if (rx_state == RX_RECEIVING && idle_cnt > idle_limit) begin
          rx_state = RX_ERROR;
          idle_cnt = '0;
          push_event(EV_TIMEOUT, 1'b0, 8'd0);
        end
      end
      OP_RESET: begin
        rx_state    = RX_WAITING;
        frame_cnt   = '0;
        byte_cnt    = '0;
        remote_errs = '0;
        next_seq    = '0;
        byte_pos    = 0;
        frame_bad   = 1'b0;
      end
      OP_BYTE: begin
        if (byte_pos >= FRAME_LIMIT) begin
          frame_bad = 1'b1;
        end else begin
          if (byte_pos == 0 && w.data_byte != FLAG_BYTE) frame_bad = 1'b1;
          else if (byte_pos == 1) hdr_addr = w.data_byte;
          else if (byte_pos == 2) hdr_ctl = w.data_byte;
          else if (byte_pos == 3) hdr_seq = w.data_byte;
          else if (byte_pos == 5) pay_len[15:8] = w.data_byte;
          else if (byte_pos == 6) pay_len[7:0] = w.data_byte;
        end
        if (!w.last_byte) begin
          if (byte_pos < FRAME_LIMIT) byte_pos++;
        end else begin
          total = byte_pos + 1;
          ok = !frame_bad && total >= FRAME_OVERHEAD && w.data_byte == FLAG_BYTE &&
               total == FRAME_OVERHEAD + int'(pay_len) && pay_len <= MAX_PAYLOAD_DEF;
          byte_pos  = 0;
          frame_bad = 1'b0;
          if (!ok) push_event(EV_BAD_FRAME, 1'b0, 8'd0);
          else handle_good_frame();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_word(logic [1:0] op, logic [7:0] b, logic l);
    rx_word_t w;
    w.opcode    = op;
    w.data_byte = b;
    w.last_byte = l;
    pending_words.push_back(w);
  endfunction

  function automatic logic [7:0] not_flag();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == FLAG_BYTE) b = 8'h00;
    return b;
  endfunction

  // queue a whole frame, optionally damaged
  function automatic void push_frame(logic [7:0] addr, logic [7:0] ctl, logic [7:0] seq,
                                     logic [15:0] len_field, int body, frame_flaw_e flaw);
    logic [7:0] q[$];
    int n;
    q.push_back(flaw == FLAW_START ? not_flag() : FLAG_BYTE);
    q.push_back(addr);
    q.push_back(ctl);
    q.push_back(seq);
    q.push_back(8'($urandom));
    q.push_back(len_field[15:8]);
    q.push_back(len_field[7:0]);
    repeat (body) q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(flaw == FLAW_END ? not_flag() : FLAG_BYTE);
    n = (flaw == FLAW_TRUNC) ? $urandom_range(1, FRAME_OVERHEAD - 1) : q.size();
    for (int i = 0; i < n; i++) push_word(OP_BYTE, q[i], i == n - 1);
  endfunction

  function automatic void push_good(logic [7:0] addr, logic [7:0] ctl, logic [7:0] seq,
                                    int len);
    push_frame(addr, ctl, seq, 16'(len), len, FLAW_NONE);
  endfunction

  // random noise word, random well-formed frame or damaged frame
  function automatic void push_noise();
    frame_flaw_e fl;
    int len;
    case ($urandom_range(5))
      0: push_word(OP_TICK, 8'($urandom), 1'($urandom));
      1: push_word(2'd3, 8'($urandom), 1'($urandom));
      2: push_word(OP_BYTE, 8'($urandom), 1'($urandom));
      3: push_good(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(4));
      default: begin
        fl  = frame_flaw_e'($urandom_range(1, 3));
        len = $urandom_range(6);
        push_frame(own_addr, 8'($urandom_range(7)), 8'($urandom), 16'(len), len, fl);
      end
    endcase
  endfunction

  // a well-formed session with random content
  function automatic void push_session();
    logic [7:0] a;
    a = ($urandom_range(3) == 0) ? BROADCAST_ADDR : own_addr;
    if ($urandom_range(2) == 0) push_word(OP_RESET, 8'($urandom), 1'($urandom));
    push_good(a, CTL_HANDSHAKE, 8'($urandom), $urandom_range(2));
    if ($urandom_range(2) == 0) gen_seq = 8'd0;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(4) == 0) push_noise();
      if ($urandom_range(5) == 0) push_word(OP_TICK, 8'($urandom), 1'($urandom));
      push_good(a, CTL_DATA, gen_seq + 8'($urandom_range(0, 5)) - 8'd1, $urandom_range(4));
      gen_seq = gen_seq + 8'd1;
    end
    case ($urandom_range(3))
      0: push_good(a, CTL_REM_ERROR, 8'($urandom), $urandom_range(3));
      1: push_word(OP_RESET, 8'($urandom), 1'($urandom));
      default: push_good(a, CTL_FINISH, 8'($urandom), $urandom_range(3));
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_NODE_ADDR: own_addr = value[7:0];
      REG_WINDOW:    window = value[7:0];
      default:       idle_limit = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_events.size() == 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] a, logic [7:0] w, logic [15:0] t);
    drain();
    write_reg(REG_NODE_ADDR, 16'(a));
    write_reg(REG_WINDOW, 16'(w));
    write_reg(REG_TIMEOUT, t);
  endtask

  task automatic random_phase(int words);
    int start;
    start = pending_words.size() + accepted_words;
    while (pending_words.size() + accepted_words - start < words) begin
      if ($urandom_range(3) == 0) push_noise();
      else push_session();
    end
  endtask

  // stimulus
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_NODE_ADDR;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_BYTE;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    own_addr    = NODE_ADDR_RST;
    window      = WINDOW_RST;
    idle_limit  = TIMEOUT_RST;
    rx_state    = RX_WAITING;
    byte_pos    = 0;
    frame_bad   = 1'b0;
    hdr_addr    = '0;
    hdr_ctl     = '0;
    hdr_seq     = '0;
    pay_len     = '0;
    next_seq    = '0;
    frame_cnt   = '0;
    byte_cnt    = '0;
    remote_errs = '0;
    idle_cnt    = '0;
    gen_seq     = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: every control, filtering, flags, lengths, overlong
    push_good(NODE_ADDR_RST, CTL_DATA, 8'd0, 0);
    push_good(NODE_ADDR_RST, CTL_FINISH, 8'd0, 0);
    push_good(8'h00, CTL_HANDSHAKE, 8'd0, 0);
    push_good(BROADCAST_ADDR, CTL_HANDSHAKE, 8'd0, 1);
    push_good(NODE_ADDR_RST, CTL_HANDSHAKE, 8'd0, 0);
    push_good(NODE_ADDR_RST, CTL_DATA, 8'd0, MAX_PAYLOAD_DEF);
    push_good(NODE_ADDR_RST, CTL_DATA, 8'd2, 3);
    push_good(NODE_ADDR_RST, CTL_DATA, 8'd5, 2);
    push_good(NODE_ADDR_RST, CTL_DATA, 8'hFF, 0);
    push_good(NODE_ADDR_RST, 8'hFF, 8'd0, 0);
    push_frame(NODE_ADDR_RST, CTL_DATA, 8'd1, 16'd65, 65, FLAW_NONE);
    push_frame(NODE_ADDR_RST, CTL_DATA, 8'd1, 16'hFFFF, 2, FLAW_NONE);
    push_frame(NODE_ADDR_RST, CTL_DATA, 8'd1, 16'd1, 1, FLAW_START);
    push_frame(NODE_ADDR_RST, CTL_DATA, 8'd1, 16'd1, 1, FLAW_END);
    push_frame(NODE_ADDR_RST, CTL_DATA, 8'd1, 16'd1, 1, FLAW_TRUNC);
    push_good(NODE_ADDR_RST, CTL_FINISH, 8'd0, 0);
    push_good(NODE_ADDR_RST, CTL_HANDSHAKE, 8'd0, 0);
    push_good(BROADCAST_ADDR, CTL_REM_ERROR, 8'd0, 0);
    push_word(2'd3, 8'hFF, 1'b1);
    push_word(OP_RESET, 8'h00, 1'b0);
    push_word(OP_TICK, 8'h00, 1'b1);
    random_phase(10);

    // narrow window, short timeout, address zero
    set_config(8'h00, 8'd1, 16'd1);
    push_good(8'h00, CTL_HANDSHAKE, 8'd0, 0);
    push_word(OP_TICK, 8'h00, 1'b0);
    push_word(OP_TICK, 8'h00, 1'b0);
    for (int i = 0; i < 8; i++) begin
      if (i % 6 == 0) push_good(8'h00, CTL_HANDSHAKE, 8'd0, 0);
      push_word(OP_TICK, 8'($urandom), 1'($urandom));
      if ($urandom_range(1)) push_word(OP_RESET, 8'($urandom), 1'($urandom));
    end
    random_phase(5);

    // widest window, longest timeout, broadcast as own address
    set_config(8'hFF, 8'd255, 16'hFFFF);
    push_good(BROADCAST_ADDR, CTL_HANDSHAKE, 8'd0, 0);
    push_good(BROADCAST_ADDR, CTL_DATA, 8'd254, 4);
    push_good(BROADCAST_ADDR, CTL_DATA, 8'd255, 4);
    random_phase(5);

    // middling settings with a short timeout
    set_config(8'($urandom_range(1, 254)), 8'($urandom_range(2, 8)), 16'd3);
    random_phase(5);
    for (int i = 0; i < 2; i++) begin
      push_good(own_addr, CTL_HANDSHAKE, 8'd0, 0);
      repeat ($urandom_range(2, 6)) push_word(OP_TICK, 8'($urandom), 1'($urandom));
      push_word(OP_RESET, 8'($urandom), 1'($urandom));
    end

    drain();
    if (!failed) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // sender: change inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || word_taken) begin
      word_taken = 1'b0;
      if (pending_words.size() > 0 &&
          ((accepted_words >= 250 && accepted_words < 330) || $urandom_range(99) >= 37)) begin
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= pending_words[0].opcode;
        in_ch.data_byte <= pending_words[0].data_byte;
        in_ch.last_byte <= pending_words[0].last_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && accepted_words >= 150) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (accepted_words >= 250 && accepted_words < 330) ||
                      ($urandom_range(99) >= 37);
    end
  end

  // accepted words feed the predictor, accepted events are checked
  always @(posedge clk) begin
    rx_event_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        frame_rx_predict(pending_words.pop_front());
        word_taken = 1'b1;
        accepted_words++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.event_res       = out_ch.event_res;
        got.ack_sent        = out_ch.ack_sent;
        got.ack_number      = out_ch.ack_number;
        got.receiver_state  = out_ch.receiver_state;
        got.frames_received = out_ch.frames_received;
        got.bytes_received  = out_ch.bytes_received;
        got.error_count     = out_ch.error_count;
        if (expected_events.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected event word: %p", got);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("event mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
